// ===== rtl/core/mac_learning_switch_with_flow_table_assert.svh =====
// assertion macros used by the switch datapath
`ifndef MAC_LEARNING_SWITCH_WITH_FLOW_TABLE_ASSERT_SVH
`define MAC_LEARNING_SWITCH_WITH_FLOW_TABLE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define MLSW_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define MLSW_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/mlsw_pkg.sv =====
// shared constants, table entry layout and controller/datapath interface types
package mlsw_pkg;

    localparam int MAC_TABLE_DEPTH  = 256;
    localparam int FLOW_TABLE_DEPTH = 256;
    localparam int PORT_BITS        = 8;

    localparam int MAC_AW  = $clog2(MAC_TABLE_DEPTH);
    localparam int MAC_CW  = $clog2(MAC_TABLE_DEPTH + 1);
    localparam int FLOW_AW = $clog2(FLOW_TABLE_DEPTH);
    localparam int FLOW_CW = $clog2(FLOW_TABLE_DEPTH + 1);
    localparam int SCAN_W  = (MAC_CW > FLOW_CW) ? MAC_CW : FLOW_CW;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] sec;
        logic [29:0] nsec;
    } flow_entry_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/core/mlsw_ram.sv =====
// generic simple dual-port ram with registered read
module mlsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (re) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/mlsw_ctrl.sv =====
// controller state machine: accept, table scan, commit
module mlsw_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mlsw_pkg::dp_stat_t stat,
    output mlsw_pkg::ctrl_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.commit = stat.out_free;
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/mlsw_dp.sv =====
// datapath: header registers, table memories, scan compare, commit and result word
`include "mac_learning_switch_with_flow_table_assert.svh"
module mlsw_dp (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mlsw_pkg::ctrl_cmd_t       cmd,
    output mlsw_pkg::dp_stat_t        stat,
    input  logic [15:0]               s_ether_type,
    input  logic [47:0]               s_src_mac,
    input  logic [47:0]               s_dst_mac,
    input  logic [31:0]               s_ip_source,
    input  logic [31:0]               s_ip_dest,
    input  logic [7:0]                s_ingress_port,
    input  logic [31:0]               s_arrival_sec,
    input  logic [29:0]               s_arrival_nsec,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_flood,
    output logic [7:0]                m_egress_port,
    output logic                      m_flow_seen,
    output logic                      m_flow_new,
    output logic                      m_flow_dropped,
    output logic [31:0]               m_first_sec,
    output logic [29:0]               m_first_nsec,
    output logic                      m_learn_dropped
);

    localparam int PB = mlsw_pkg::PORT_BITS;
    localparam int SW = mlsw_pkg::SCAN_W;

    // header word
    logic [47:0]   src_mac_reg;
    logic [47:0]   dst_mac_reg;
    logic [31:0]   lo_reg;
    logic [31:0]   hi_reg;
    logic          is_ip_reg;
    logic [PB-1:0] port_reg;
    logic [31:0]   sec_reg;
    logic [29:0]   nsec_reg;

    // table fill counts
    logic [mlsw_pkg::FLOW_CW-1:0] fcount_reg;
    logic [mlsw_pkg::MAC_CW-1:0]  mcount_reg;

    // scan state
    logic [SW-1:0] rd_addr_reg;
    logic [SW-1:0] rd_idx_reg;
    logic          rd_vld_reg;
    logic [SW-1:0] scan_lim;
    logic          issue;

    // scan results
    logic                        fhit_reg;
    logic [31:0]                 fsec_reg;
    logic [29:0]                 fnsec_reg;
    logic                        shit_reg;
    logic [mlsw_pkg::MAC_AW-1:0] sidx_reg;
    logic                        dhit_reg;
    logic [PB-1:0]               dport_reg;

    // memory ports
    mlsw_pkg::flow_entry_t flow_q;
    mlsw_pkg::flow_entry_t flow_wd;
    logic [47:0]           key_q;
    logic [PB-1:0]         port_q;
    logic                  flow_we;
    logic                  key_we;
    logic                  port_we;
    logic [mlsw_pkg::MAC_AW-1:0] port_wa;

    // commit decisions
    logic flow_full;
    logic mac_full;
    logic src_uc;
    logic learned;
    logic f_ok;
    logic m_ok;

    // output word
    logic          m_valid_reg;
    logic          flood_reg;
    logic [7:0]    egress_reg;
    logic          seen_reg;
    logic          fnew_reg;
    logic          fdrop_reg;
    logic [31:0]   first_sec_reg;
    logic [29:0]   first_nsec_reg;
    logic          ldrop_reg;

    // scan range covers the larger fill count
    always_comb begin
        if (SW'(fcount_reg) > SW'(mcount_reg)) begin
            scan_lim = SW'(fcount_reg);
        end else begin
            scan_lim = SW'(mcount_reg);
        end
    end

    assign issue          = cmd.scan && (rd_addr_reg < scan_lim);
    assign stat.scan_done = !issue && !rd_vld_reg;
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign flow_full = (fcount_reg == mlsw_pkg::FLOW_CW'(mlsw_pkg::FLOW_TABLE_DEPTH));
    assign mac_full  = (mcount_reg == mlsw_pkg::MAC_CW'(mlsw_pkg::MAC_TABLE_DEPTH));
    assign src_uc    = !src_mac_reg[40];
    assign learned   = src_uc && (shit_reg || !mac_full);

    assign f_ok = rd_vld_reg && (rd_idx_reg < SW'(fcount_reg));
    assign m_ok = rd_vld_reg && (rd_idx_reg < SW'(mcount_reg));

    // table writes
    assign flow_we = cmd.commit && is_ip_reg && !fhit_reg && !flow_full;
    assign key_we  = cmd.commit && src_uc && !shit_reg && !mac_full;
    assign port_we = cmd.commit && learned;
    assign port_wa = shit_reg ? sidx_reg : mcount_reg[mlsw_pkg::MAC_AW-1:0];

    assign flow_wd.lo   = lo_reg;
    assign flow_wd.hi   = hi_reg;
    assign flow_wd.sec  = sec_reg;
    assign flow_wd.nsec = nsec_reg;

    mlsw_ram #(
        .WIDTH ($bits(mlsw_pkg::flow_entry_t)),
        .DEPTH (mlsw_pkg::FLOW_TABLE_DEPTH)
    ) u_flow_ram (
        .aclk    (aclk),
        .we      (flow_we),
        .wr_addr (fcount_reg[mlsw_pkg::FLOW_AW-1:0]),
        .wr_data (flow_wd),
        .re      (issue),
        .rd_addr (rd_addr_reg[mlsw_pkg::FLOW_AW-1:0]),
        .rd_data (flow_q)
    );

    mlsw_ram #(
        .WIDTH (48),
        .DEPTH (mlsw_pkg::MAC_TABLE_DEPTH)
    ) u_key_ram (
        .aclk    (aclk),
        .we      (key_we),
        .wr_addr (mcount_reg[mlsw_pkg::MAC_AW-1:0]),
        .wr_data (src_mac_reg),
        .re      (issue),
        .rd_addr (rd_addr_reg[mlsw_pkg::MAC_AW-1:0]),
        .rd_data (key_q)
    );

    mlsw_ram #(
        .WIDTH (PB),
        .DEPTH (mlsw_pkg::MAC_TABLE_DEPTH)
    ) u_port_ram (
        .aclk    (aclk),
        .we      (port_we),
        .wr_addr (port_wa),
        .wr_data (port_reg),
        .re      (issue),
        .rd_addr (rd_addr_reg[mlsw_pkg::MAC_AW-1:0]),
        .rd_data (port_q)
    );

    // header capture with ordered address pair
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            src_mac_reg <= s_src_mac;
            dst_mac_reg <= s_dst_mac;
            is_ip_reg   <= (s_ether_type == mlsw_pkg::ETHERTYPE_IPV4);
            port_reg    <= PB'(s_ingress_port);
            sec_reg     <= s_arrival_sec;
            nsec_reg    <= s_arrival_nsec;
            if (s_ip_source < s_ip_dest) begin
                lo_reg <= s_ip_source;
                hi_reg <= s_ip_dest;
            end else begin
                lo_reg <= s_ip_dest;
                hi_reg <= s_ip_source;
            end
        end
    end

    // scan address and read pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_addr_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (cmd.load) begin
                rd_addr_reg <= '0;
            end else if (issue) begin
                rd_addr_reg <= rd_addr_reg + SW'(1);
            end
            rd_vld_reg <= issue;
        end
        rd_idx_reg <= rd_addr_reg;
    end

    // compare each returned entry against the header
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            fhit_reg <= 1'b0;
            shit_reg <= 1'b0;
            dhit_reg <= 1'b0;
        end else begin
            if (f_ok && flow_q.lo == lo_reg && flow_q.hi == hi_reg) begin
                fhit_reg  <= 1'b1;
                fsec_reg  <= flow_q.sec;
                fnsec_reg <= flow_q.nsec;
            end
            if (m_ok && key_q == src_mac_reg) begin
                shit_reg <= 1'b1;
                sidx_reg <= rd_idx_reg[mlsw_pkg::MAC_AW-1:0];
            end
            if (m_ok && key_q == dst_mac_reg) begin
                dhit_reg  <= 1'b1;
                dport_reg <= port_q;
            end
        end
    end

    // fill counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fcount_reg <= '0;
            mcount_reg <= '0;
        end else begin
            if (flow_we) begin
                fcount_reg <= fcount_reg + mlsw_pkg::FLOW_CW'(1);
            end
            if (key_we) begin
                mcount_reg <= mcount_reg + mlsw_pkg::MAC_CW'(1);
            end
        end
    end

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result word; a destination equal to a just-learned source takes the new port
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            seen_reg  <= is_ip_reg;
            fnew_reg  <= is_ip_reg && !fhit_reg && !flow_full;
            fdrop_reg <= is_ip_reg && !fhit_reg && flow_full;
            ldrop_reg <= src_uc && !learned;
            if (!is_ip_reg) begin
                first_sec_reg  <= '0;
                first_nsec_reg <= '0;
            end else if (fhit_reg) begin
                first_sec_reg  <= fsec_reg;
                first_nsec_reg <= fnsec_reg;
            end else begin
                first_sec_reg  <= sec_reg;
                first_nsec_reg <= nsec_reg;
            end
            if (dst_mac_reg[40]) begin
                flood_reg  <= 1'b1;
                egress_reg <= '0;
            end else if (learned && dst_mac_reg == src_mac_reg) begin
                flood_reg  <= 1'b0;
                egress_reg <= 8'(port_reg);
            end else if (dhit_reg) begin
                flood_reg  <= 1'b0;
                egress_reg <= 8'(dport_reg);
            end else begin
                flood_reg  <= 1'b1;
                egress_reg <= '0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_flood         = flood_reg;
    assign m_egress_port   = egress_reg;
    assign m_flow_seen     = seen_reg;
    assign m_flow_new      = fnew_reg;
    assign m_flow_dropped  = fdrop_reg;
    assign m_first_sec     = first_sec_reg;
    assign m_first_nsec    = first_nsec_reg;
    assign m_learn_dropped = ldrop_reg;

    `MLSW_ASSERT_ALWAYS(a_fcount_range, aclk, aresetn, fcount_reg <= mlsw_pkg::FLOW_CW'(mlsw_pkg::FLOW_TABLE_DEPTH), "flow fill count beyond table depth")
    `MLSW_ASSERT_ALWAYS(a_mcount_range, aclk, aresetn, mcount_reg <= mlsw_pkg::MAC_CW'(mlsw_pkg::MAC_TABLE_DEPTH), "mac fill count beyond table depth")
    `MLSW_ASSERT_IMPL(a_commit_drained, aclk, aresetn, cmd.commit, !rd_vld_reg && !issue, "commit while table scan still in flight")

endmodule

// ===== rtl/core/mac_learning_switch_with_flow_table.sv =====
// top level: learning switch with ipv4 flow table
// one header word at a time; a new word is accepted only after the last one is committed;
// the result waits on a one-entry-per-cycle scan of both tables up to the larger fill count
// and on the output register being free (or m_ready) before it is committed
// aresetn (synchronous, active low) empties both tables by clearing their fill counts
// and drops any word in flight; no clearing pass is needed
module mac_learning_switch_with_flow_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_ether_type,
    input  logic [47:0] s_src_mac,
    input  logic [47:0] s_dst_mac,
    input  logic [31:0] s_ip_source,
    input  logic [31:0] s_ip_dest,
    input  logic [7:0]  s_ingress_port,
    input  logic [31:0] s_arrival_sec,
    input  logic [29:0] s_arrival_nsec,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_flood,
    output logic [7:0]  m_egress_port,
    output logic        m_flow_seen,
    output logic        m_flow_new,
    output logic        m_flow_dropped,
    output logic [31:0] m_first_sec,
    output logic [29:0] m_first_nsec,
    output logic        m_learn_dropped
);

    mlsw_pkg::ctrl_cmd_t cmd;
    mlsw_pkg::dp_stat_t  stat;

    // sequencer
    mlsw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // tables and result path
    mlsw_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_ether_type    (s_ether_type),
        .s_src_mac       (s_src_mac),
        .s_dst_mac       (s_dst_mac),
        .s_ip_source     (s_ip_source),
        .s_ip_dest       (s_ip_dest),
        .s_ingress_port  (s_ingress_port),
        .s_arrival_sec   (s_arrival_sec),
        .s_arrival_nsec  (s_arrival_nsec),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_flood         (m_flood),
        .m_egress_port   (m_egress_port),
        .m_flow_seen     (m_flow_seen),
        .m_flow_new      (m_flow_new),
        .m_flow_dropped  (m_flow_dropped),
        .m_first_sec     (m_first_sec),
        .m_first_nsec    (m_first_nsec),
        .m_learn_dropped (m_learn_dropped)
    );

endmodule
